/* design/plc_pkg.sv */
package plc_pkg;

	// Field widths of the command and result channels.
	localparam int CMD_W    = 3;
	localparam int POS_W    = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;

	// Command codes. Code seven is handled as a show.
	localparam logic [CMD_W-1:0] CMD_ADD_FIRST = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_LAST  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD_AT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SHOW      = 3'd6;

	// Status codes carried by the status item.
	localparam logic [STATUS_W-1:0] STS_DONE   = 3'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY  = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BADPOS = 3'd2;
	localparam logic [STATUS_W-1:0] STS_BELOW  = 3'd3;
	localparam logic [STATUS_W-1:0] STS_FULL   = 3'd4;

	// Result item kinds.
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_ELEMENT = 1'b1;

	// Operation broadcast to every cell of the row.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_ROTATE = 2'd3
	} plc_op_t;

	typedef struct packed {
		plc_op_t                    op;
		logic signed [VALUE_W-1:0]  value;
	} plc_ctrl_t;

endpackage

/* design/plc_cell.sv */
module plc_cell #(
	parameter int IW = 5
) (
	input  logic                                  clk,
	input  plc_pkg::plc_ctrl_t                    ctrl,
	input  logic [IW-1:0]                         pos_k,
	input  logic [IW-1:0]                         cell_idx,
	input  logic signed [plc_pkg::VALUE_W-1:0]    left_in,
	input  logic signed [plc_pkg::VALUE_W-1:0]    right_in,
	output logic signed [plc_pkg::VALUE_W-1:0]    data_q
);

	logic signed [plc_pkg::VALUE_W-1:0] data_nxt;

	// Insert opens a gap at the target slot, delete closes it, rotate moves toward the head.
	always_comb begin
		data_nxt = data_q;
		unique case (ctrl.op)
			plc_pkg::OP_HOLD: begin
				data_nxt = data_q;
			end
			plc_pkg::OP_INSERT: begin
				priority if (cell_idx == pos_k) begin
					data_nxt = ctrl.value;
				end else if (cell_idx > pos_k) begin
					data_nxt = left_in;
				end else begin
					data_nxt = data_q;
				end
			end
			plc_pkg::OP_DELETE: begin
				if (cell_idx >= pos_k) begin
					data_nxt = right_in;
				end
			end
			plc_pkg::OP_ROTATE: begin
				data_nxt = right_in;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

endmodule

/* design/plc_chain.sv */
module plc_chain #(
	parameter int CAPACITY = 32
) (
	input  logic                                          clk,
	input  plc_pkg::plc_ctrl_t                            ctrl,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] pos_k,
	output logic signed [plc_pkg::VALUE_W-1:0]            head
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic signed [plc_pkg::VALUE_W-1:0] cell_data [CAPACITY];

	// Row of cells; the far end wraps to the head so a rotation walks the whole list.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [plc_pkg::VALUE_W-1:0] left_w;
		logic signed [plc_pkg::VALUE_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[0];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		plc_cell #(
			.IW(IW)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.pos_k    (pos_k),
			.cell_idx (IW'(i)),
			.left_in  (left_w),
			.right_in (right_w),
			.data_q   (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

/* design/positional_list_engine_top.sv */
// Positional list engine: a bounded list of signed 32-bit values held in order
// in a row of CAPACITY cells, position one in the first cell.
// Command channel (cmd, position, value) and result channel (item_kind, status,
// element, last_item) both use valid and stall; a transfer happens on a clock
// edge with valid high and stall low.
// Each command gives one status item. Unless it fails on a position or on a
// full list, the status item is followed by the elements from head to tail;
// the final item of every command has last_item set.
// The command passes the execute state, where insert and delete are applied in
// the cell row with all cells moving together, and then the status state, from
// which the status item is registered at the output. The readout then rotates
// the row through CAPACITY steps, one element per cycle from the first cell
// while the result channel does not stall. The next command is taken once the
// rotation ends, or once the status item is registered when no list follows.
// A stall on the result channel freezes the rotation while an element waits;
// the output register holds its item until it is taken.
// Reset empties the list and clears the pending result; stored values are not
// cleared, since a cell is only read after it has been written.
module positional_list_engine_top #(
	parameter int CAPACITY = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_stall,
	input  logic [plc_pkg::CMD_W-1:0]             cmd,
	input  logic [plc_pkg::POS_W-1:0]             position,
	input  logic signed [plc_pkg::VALUE_W-1:0]    value,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic                                  item_kind,
	output logic [plc_pkg::STATUS_W-1:0]          status,
	output logic signed [plc_pkg::VALUE_W-1:0]    element,
	output logic                                  last_item
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_STAT = 4'b0100,
		ST_READ = 4'b1000
	} state_t;

	state_t                               state_q;
	logic [plc_pkg::CMD_W-1:0]            cmd_q;
	logic [plc_pkg::POS_W-1:0]            pos_q;
	logic signed [plc_pkg::VALUE_W-1:0]   value_q;
	logic [CW-1:0]                        count_q;
	logic [plc_pkg::STATUS_W-1:0]         code_q;
	logic                                 with_list_q;
	logic [IW-1:0]                        step_q;

	logic                                 res_valid_q;
	logic                                 item_kind_q;
	logic [plc_pkg::STATUS_W-1:0]         status_q;
	logic signed [plc_pkg::VALUE_W-1:0]   element_q;
	logic                                 last_q;

	logic                                 cmd_xfer;
	logic                                 out_free;
	logic                                 full;
	logic [plc_pkg::POS_W:0]              pos_x;
	logic [plc_pkg::POS_W:0]              cnt_x;
	logic [plc_pkg::STATUS_W-1:0]         ex_code;
	logic                                 ex_list;
	plc_pkg::plc_op_t                     ex_op;
	logic [IW-1:0]                        ex_k;
	logic [CW-1:0]                        list_n;
	logic                                 want_emit;
	logic                                 read_rotate;
	logic                                 step_last;
	logic                                 stat_emit;
	logic                                 read_emit;
	plc_pkg::plc_ctrl_t                   chain_ctrl;
	logic signed [plc_pkg::VALUE_W-1:0]   head_value;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_xfer  = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// Command decode against the current fill count.
	assign full  = (count_q == CW'(CAPACITY));
	assign pos_x = {1'b0, pos_q};
	assign cnt_x = (plc_pkg::POS_W + 1)'(count_q);

	always_comb begin
		ex_code = plc_pkg::STS_DONE;
		ex_list = 1'b1;
		ex_op   = plc_pkg::OP_HOLD;
		ex_k    = '0;
		unique case (cmd_q)
			plc_pkg::CMD_ADD_FIRST, plc_pkg::CMD_ADD_LAST: begin
				if (full) begin
					ex_code = plc_pkg::STS_FULL;
					ex_list = 1'b0;
				end else begin
					ex_op = plc_pkg::OP_INSERT;
					ex_k  = (cmd_q == plc_pkg::CMD_ADD_FIRST) ? '0 : IW'(count_q);
				end
			end
			plc_pkg::CMD_ADD_AT: begin
				priority if (pos_q == '0) begin
					ex_code = plc_pkg::STS_BELOW;
					ex_list = 1'b0;
				end else if (pos_x > cnt_x + 1'b1) begin
					ex_code = plc_pkg::STS_BADPOS;
					ex_list = 1'b0;
				end else if (full) begin
					ex_code = plc_pkg::STS_FULL;
					ex_list = 1'b0;
				end else begin
					ex_op = plc_pkg::OP_INSERT;
					ex_k  = IW'(pos_q - 1'b1);
				end
			end
			plc_pkg::CMD_DEL_FIRST, plc_pkg::CMD_DEL_LAST: begin
				if (count_q == '0) begin
					ex_code = plc_pkg::STS_EMPTY;
				end else begin
					ex_op = plc_pkg::OP_DELETE;
					ex_k  = (cmd_q == plc_pkg::CMD_DEL_FIRST) ? '0 : IW'(count_q - 1'b1);
				end
			end
			plc_pkg::CMD_DEL_AT: begin
				priority if (pos_q == '0) begin
					ex_code = plc_pkg::STS_BELOW;
					ex_list = 1'b0;
				end else if (pos_q == plc_pkg::POS_W'(1) && count_q == '0) begin
					ex_code = plc_pkg::STS_EMPTY;
				end else if (pos_x > cnt_x) begin
					ex_code = plc_pkg::STS_BADPOS;
					ex_list = 1'b0;
				end else begin
					ex_op = plc_pkg::OP_DELETE;
					ex_k  = IW'(pos_q - 1'b1);
				end
			end
			default: begin
				// Show, and the unused code seven.
				if (count_q == '0) begin
					ex_code = plc_pkg::STS_EMPTY;
				end
			end
		endcase
	end

	// Readout bookkeeping: the first list_n rotation steps each give one element.
	assign list_n      = with_list_q ? count_q : '0;
	assign want_emit   = (CW'(step_q) < list_n);
	assign read_rotate = (state_q == ST_READ) && (want_emit ? out_free : 1'b1);
	assign step_last   = (step_q == IW'(CAPACITY - 1));
	assign stat_emit   = (state_q == ST_STAT) && out_free;
	assign read_emit   = (state_q == ST_READ) && want_emit && out_free;

	// Control broadcast to the cell row.
	always_comb begin
		chain_ctrl.value = value_q;
		chain_ctrl.op    = plc_pkg::OP_HOLD;
		if (state_q == ST_EXEC) begin
			chain_ctrl.op = ex_op;
		end else if (read_rotate) begin
			chain_ctrl.op = plc_pkg::OP_ROTATE;
		end
	end

	plc_chain #(
		.CAPACITY(CAPACITY)
	) u_chain (
		.clk   (clk),
		.ctrl  (chain_ctrl),
		.pos_k (ex_k),
		.head  (head_value)
	);

	// Sequencer: take a command, apply it, send the status, rotate out the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ex_op == plc_pkg::OP_INSERT) begin
						count_q <= count_q + 1'b1;
					end else if (ex_op == plc_pkg::OP_DELETE) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= ST_STAT;
				end
				ST_STAT: begin
					if (out_free) begin
						step_q  <= '0;
						state_q <= (list_n == '0) ? ST_IDLE : ST_READ;
					end
				end
				ST_READ: begin
					if (read_rotate) begin
						if (step_last) begin
							step_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command and decode holding registers.
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_q   <= cmd;
			pos_q   <= position;
			value_q <= value;
		end
		if (state_q == ST_EXEC) begin
			code_q      <= ex_code;
			with_list_q <= ex_list;
		end
	end

	// Output register: holds a result item until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat_emit || read_emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat_emit) begin
			item_kind_q <= plc_pkg::KIND_STATUS;
			status_q    <= code_q;
			element_q   <= '0;
			last_q      <= (list_n == '0);
		end else if (read_emit) begin
			item_kind_q <= plc_pkg::KIND_ELEMENT;
			status_q    <= plc_pkg::STS_DONE;
			element_q   <= head_value;
			last_q      <= (CW'(step_q) == list_n - 1'b1);
		end
	end

	assign res_valid = res_valid_q;
	assign item_kind = item_kind_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last_item = last_q;

	// The fill count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// The list length only changes while a command is being applied.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EXEC |=> $stable(count_q))
		else $error("fill count changed outside command execution");

	// When the rotation ends, whatever still waits at the output closes the command.
	a_read_closes: assert property (@(posedge clk) disable iff (!arst_n)
		read_rotate && step_last |=> !res_valid_q || last_q)
		else $error("readout ended without a final item");

endmodule

/* sim/tb_positional_list_engine_top.sv */
`timescale 1ns / 100ps

module tb_positional_list_engine_top;

	localparam int CAPACITY     = 32;
	localparam int RANDOM_ITEMS = 220;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = CAPACITY + 8;
	localparam int SCRIPT_ROWS  = 26;
	localparam int REPORT_LIMIT = 10;

	// Spare command code, handled by the block as a show.
	localparam logic [plc_pkg::CMD_W-1:0] CMD_SPARE = 3'd7;

	typedef struct packed {
		logic                                kind;
		logic [plc_pkg::STATUS_W-1:0]        status;
		logic signed [plc_pkg::VALUE_W-1:0]  element;
		logic                                last;
	} list_item_t;

	typedef struct packed {
		logic [plc_pkg::CMD_W-1:0]     cmd;
		logic [plc_pkg::POS_W-1:0]     pos;
		logic [plc_pkg::VALUE_W-1:0]   value;
		logic [5:0]                    reps;
		logic                          typed;
		logic [plc_pkg::STATUS_W-1:0]  typed_status;
	} script_row_t;

	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 cmd_valid = 1'b0;
	logic                                 cmd_stall;
	logic [plc_pkg::CMD_W-1:0]            cmd       = '0;
	logic [plc_pkg::POS_W-1:0]            position  = '0;
	logic signed [plc_pkg::VALUE_W-1:0]   value     = '0;
	logic                                 res_valid;
	logic                                 res_stall = 1'b1;
	logic                                 item_kind;
	logic [plc_pkg::STATUS_W-1:0]         status;
	logic signed [plc_pkg::VALUE_W-1:0]   element;
	logic                                 last_item;

	// Shadow copy of the list, head first, and the results still owed.
	logic signed [plc_pkg::VALUE_W-1:0]   list_values[$];
	list_item_t                           owed_items[$];
	int unsigned                          fault_count = 0;

	// Traffic shaping; steady applies to both sides, the hold-off to the result side.
	bit                                   steady     = 1'b0;
	bit                                   hold_now   = 1'b0;
	bit                                   hold_taken = 1'b0;
	int                                   hold_left  = 0;

	script_row_t                          script [SCRIPT_ROWS];

	positional_list_engine_top #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.position(position),
		.value(value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.item_kind(item_kind),
		.status(status),
		.element(element),
		.last_item(last_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted command to the shadow list and queue what it answers.
	task automatic predict_list_command(input logic [plc_pkg::CMD_W-1:0] c,
			input logic [plc_pkg::POS_W-1:0] p,
			input logic signed [plc_pkg::VALUE_W-1:0] v, input bit typed,
			input logic [plc_pkg::STATUS_W-1:0] typed_status);
		logic [plc_pkg::STATUS_W-1:0] st;
		bit                           with_list;
		int                           count;
		int                           n;
		list_item_t                   it;
		count     = list_values.size();
		with_list = 1'b1;
		st        = plc_pkg::STS_DONE;
		case (c)
			plc_pkg::CMD_ADD_FIRST, plc_pkg::CMD_ADD_LAST: begin
				if (count >= CAPACITY) begin
					st = plc_pkg::STS_FULL;
					with_list = 1'b0;
				end else if (c == plc_pkg::CMD_ADD_FIRST) begin
					list_values.push_front(v);
				end else begin
					list_values.push_back(v);
				end
			end
			plc_pkg::CMD_ADD_AT: begin
				if (p == 0) begin
					st = plc_pkg::STS_BELOW;
					with_list = 1'b0;
				end else if (p > count + 1) begin
					st = plc_pkg::STS_BADPOS;
					with_list = 1'b0;
				end else if (count >= CAPACITY) begin
					st = plc_pkg::STS_FULL;
					with_list = 1'b0;
				end else begin
					list_values.insert(p - 1, v);
				end
			end
			plc_pkg::CMD_DEL_FIRST, plc_pkg::CMD_DEL_LAST: begin
				if (count == 0)
					st = plc_pkg::STS_EMPTY;
				else if (c == plc_pkg::CMD_DEL_FIRST)
					void'(list_values.pop_front());
				else
					void'(list_values.pop_back());
			end
			plc_pkg::CMD_DEL_AT: begin
				if (p == 0) begin
					st = plc_pkg::STS_BELOW;
					with_list = 1'b0;
				end else if (p == 1 && count == 0) begin
					st = plc_pkg::STS_EMPTY;
				end else if (p > count) begin
					st = plc_pkg::STS_BADPOS;
					with_list = 1'b0;
				end else begin
					list_values.delete(p - 1);
				end
			end
			default: begin
				if (count == 0)
					st = plc_pkg::STS_EMPTY;
			end
		endcase
		if (typed)
			st = typed_status;
		n = with_list ? list_values.size() : 0;
		it.kind    = plc_pkg::KIND_STATUS;
		it.status  = st;
		it.element = '0;
		it.last    = (n == 0);
		owed_items.push_back(it);
		for (int i = 0; i < n; i++) begin
			it.kind    = plc_pkg::KIND_ELEMENT;
			it.status  = plc_pkg::STS_DONE;
			it.element = list_values[i];
			it.last    = (i == n - 1);
			owed_items.push_back(it);
		end
	endtask

	// Offer one command, idling first at random outside steady stretches, and hold it until the transfer.
	task automatic offer_command(input logic [plc_pkg::CMD_W-1:0] c,
			input logic [plc_pkg::POS_W-1:0] p,
			input logic signed [plc_pkg::VALUE_W-1:0] v, input bit typed,
			input logic [plc_pkg::STATUS_W-1:0] typed_status);
		while (!steady && $urandom_range(0, 99) < 12) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		position  <= p;
		value     <= v;
		do
			@(posedge clk);
		while (cmd_stall);
		predict_list_command(c, p, v, typed, typed_status);
	endtask

	// Result side stall: random, quiet during steady stretches, or one long hold-off.
	always @(posedge clk) begin
		if (hold_now && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else if (steady) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(0, 99) < 12);
		end
	end

	// Compare every result transfer with the oldest owed item.
	always @(posedge clk) begin
		list_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (owed_items.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result: kind %0d status %0d element %0d last %0d",
						item_kind, status, element, last_item);
			end else begin
				want = owed_items.pop_front();
				if (item_kind !== want.kind || status !== want.status ||
						element !== want.element || last_item !== want.last) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display({"result mismatch: expected kind %0d status %0d ",
							"element %0d last %0d, got kind %0d status %0d ",
							"element %0d last %0d"},
							want.kind, want.status, want.element, want.last,
							item_kind, status, element, last_item);
				end
			end
		end
	end

	// Stimulus: directed script, then random traffic, then drain.
	initial begin : stimulus
		script_row_t                         row;
		logic [plc_pkg::CMD_W-1:0]           c;
		logic [plc_pkg::POS_W-1:0]           p;
		logic signed [plc_pkg::VALUE_W-1:0]  v;
		int                                  r;
		int                                  count;
		bit                                  filling;

		script = '{
			'{plc_pkg::CMD_SHOW,      8'd0,   32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_EMPTY},
			'{plc_pkg::CMD_DEL_FIRST, 8'd0,   32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_EMPTY},
			'{plc_pkg::CMD_DEL_LAST,  8'd0,   32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_EMPTY},
			'{plc_pkg::CMD_DEL_AT,    8'd1,   32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_EMPTY},
			'{plc_pkg::CMD_DEL_AT,    8'd2,   32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_BADPOS},
			'{plc_pkg::CMD_DEL_AT,    8'd0,   32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_BELOW},
			'{plc_pkg::CMD_ADD_AT,    8'd0,   32'h1234_5678, 6'd1,  1'b1, plc_pkg::STS_BELOW},
			'{plc_pkg::CMD_ADD_AT,    8'd2,   32'h1234_5678, 6'd1,  1'b1, plc_pkg::STS_BADPOS},
			'{plc_pkg::CMD_ADD_FIRST, 8'd0,   32'h7FFF_FFFF, 6'd1,  1'b1, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_ADD_LAST,  8'd255, 32'h8000_0000, 6'd1,  1'b1, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_ADD_AT,    8'd2,   32'hFFFF_FFFF, 6'd1,  1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_ADD_AT,    8'd4,   32'h0000_0000, 6'd1,  1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_ADD_AT,    8'd255, 32'h0000_0001, 6'd1,  1'b1, plc_pkg::STS_BADPOS},
			'{CMD_SPARE,              8'd0,   32'h0000_0000, 6'd1,  1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_DEL_AT,    8'd2,   32'h0000_0000, 6'd1,  1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_DEL_AT,    8'd3,   32'h0000_0000, 6'd1,  1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_DEL_AT,    8'd255, 32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_BADPOS},
			'{plc_pkg::CMD_ADD_LAST,  8'd0,   32'h5555_5555, 6'd30, 1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_ADD_FIRST, 8'd0,   32'h0BAD_0001, 6'd1,  1'b1, plc_pkg::STS_FULL},
			'{plc_pkg::CMD_ADD_AT,    8'd33,  32'h0BAD_0002, 6'd1,  1'b1, plc_pkg::STS_FULL},
			'{plc_pkg::CMD_ADD_AT,    8'd34,  32'h0BAD_0003, 6'd1,  1'b1, plc_pkg::STS_BADPOS},
			'{plc_pkg::CMD_ADD_AT,    8'd1,   32'hAAAA_AAAA, 6'd1,  1'b1, plc_pkg::STS_FULL},
			'{plc_pkg::CMD_DEL_AT,    8'd32,  32'h0000_0000, 6'd1,  1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_ADD_AT,    8'd32,  32'hAAAA_AAAA, 6'd1,  1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_DEL_FIRST, 8'd0,   32'h0000_0000, 6'd32, 1'b0, plc_pkg::STS_DONE},
			'{plc_pkg::CMD_SHOW,      8'd0,   32'h0000_0000, 6'd1,  1'b1, plc_pkg::STS_EMPTY}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script; repeated rows step the value so each entry differs.
		for (int k = 0; k < SCRIPT_ROWS; k++) begin
			row = script[k];
			for (int rep = 0; rep < row.reps; rep++)
				offer_command(row.cmd, row.pos, row.value + rep, row.typed,
					row.typed_status);
		end

		// Random traffic in alternating fill and drain phases.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady  = (i >= 60 && i < 120) || (i >= 150 && i < 180);
			if (i == 150)
				hold_now = 1'b1;
			if (i == 200) begin
				cmd_valid <= 1'b0;
				while (owed_items.size() != 0)
					@(posedge clk);
			end
			filling = ((i / 60) % 2 == 0);
			count   = list_values.size();
			r       = $urandom_range(0, 99);
			if (r < 4) begin
				c = CMD_SPARE;
			end else if (r < 12) begin
				c = plc_pkg::CMD_SHOW;
			end else if (r < (filling ? 80 : 35)) begin
				case ($urandom_range(0, 2))
					0:       c = plc_pkg::CMD_ADD_FIRST;
					1:       c = plc_pkg::CMD_ADD_LAST;
					default: c = plc_pkg::CMD_ADD_AT;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0:       c = plc_pkg::CMD_DEL_FIRST;
					1:       c = plc_pkg::CMD_DEL_LAST;
					default: c = plc_pkg::CMD_DEL_AT;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 8)
				p = '0;
			else if (r < 20)
				p = plc_pkg::POS_W'($urandom_range(0, 255));
			else
				p = plc_pkg::POS_W'($urandom_range(1, count + 1));
			if ($urandom_range(0, 99) < 15) begin
				case ($urandom_range(0, 3))
					0:       v = 32'sh8000_0000;
					1:       v = 32'sh7FFF_FFFF;
					2:       v = 32'sh0000_0000;
					default: v = 32'shFFFF_FFFF;
				endcase
			end else begin
				v = $urandom;
			end
			offer_command(c, p, v, 1'b0, plc_pkg::STS_DONE);
		end
		steady = 1'b0;
		cmd_valid <= 1'b0;

		// Drain, then give the block time to show anything extra.
		while (owed_items.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
